FILE: hdl/toaster_oven_controller_defines.svh
// Assertion macros for the toaster oven controller.
`ifndef TOASTER_OVEN_CONTROLLER_DEFINES_SVH
`define TOASTER_OVEN_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

`define TOC_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("toc invariant failed");

`define TOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("toc sequence check failed");

`else

`define TOC_ASSERT(label, expr)

`define TOC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/toc_pkg.sv
// Types and constants shared by the toaster oven controller.
package toc_pkg;

    localparam logic [2:0] PH_SETUP  = 3'd0;
    localparam logic [2:0] PH_SELECT = 3'd1;
    localparam logic [2:0] PH_COOK   = 3'd2;
    localparam logic [2:0] PH_RESET  = 3'd3;
    localparam logic [2:0] PH_FLASH  = 3'd4;

    localparam logic [1:0] MODE_BAKE  = 2'd0;
    localparam logic [1:0] MODE_TOAST = 2'd1;
    localparam logic [1:0] MODE_BROIL = 2'd2;

    localparam logic CFG_BROIL  = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    // elapsed-ticks-within-second counter; covers ticks-per-second up to 64
    localparam int SUB_W = 6;

    typedef struct packed {
        logic       tick;
        logic       adc_fresh;
        logic [9:0] adc_sample;
        logic [3:0] button_events;
    } event_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  cook_mode;
        logic [8:0]  cook_seconds;
        logic [8:0]  seconds_left;
        logic [10:0] oven_temperature;
        logic        editing_temperature;
        logic [7:0]  led_bar;
        logic        display_inverted;
    } result_t;

    typedef struct packed {
        logic [9:0] broil;
        logic [9:0] offset;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       phase;
        logic [1:0]       mode;
        logic [8:0]       cook;
        logic [8:0]       left;
        logic [10:0]      temp;
        logic [10:0]      saved;
        logic             edit;
        logic [15:0]      stamp;
        logic [15:0]      frc;
        logic [SUB_W-1:0] sub;
        logic [15:0]      tcount;
        logic [15:0]      interval;
        logic [2:0]       rem;
        logic [7:0]       led;
        logic             flash;
    } state_t;

    localparam cfg_t CFG_RESET = '{broil: 10'd500, offset: 10'd300};

    localparam state_t STATE_RESET = '{
        phase:    PH_SETUP,
        mode:     MODE_BAKE,
        cook:     9'd1,
        left:     9'd1,
        temp:     11'd350,
        saved:    11'd0,
        edit:     1'b0,
        stamp:    16'd0,
        frc:      16'd0,
        sub:      '0,
        tcount:   16'd0,
        interval: 16'd0,
        rem:      3'd0,
        led:      8'd0,
        flash:    1'b0
    };

endpackage

FILE: hdl/toc_channels.sv
// Handshake channels of the toaster oven controller: events, results, register writes.
interface toc_event_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic       adc_fresh;
    logic [9:0] adc_sample;
    logic [3:0] button_events;

    modport source (output valid, tick, adc_fresh, adc_sample, button_events, input ready);
    modport sink (input valid, tick, adc_fresh, adc_sample, button_events, output ready);
endinterface

interface toc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic [1:0]  cook_mode;
    logic [8:0]  cook_seconds;
    logic [8:0]  seconds_left;
    logic [10:0] oven_temperature;
    logic        editing_temperature;
    logic [7:0]  led_bar;
    logic        display_inverted;

    modport source (
        output valid, phase, cook_mode, cook_seconds, seconds_left, oven_temperature,
               editing_temperature, led_bar, display_inverted,
        input  ready
    );
    modport sink (
        input  valid, phase, cook_mode, cook_seconds, seconds_left, oven_temperature,
               editing_temperature, led_bar, display_inverted,
        output ready
    );
endinterface

interface toc_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/toc_step.sv
// Next-state and result logic for one event word of the oven controller.
module toc_step #(
    parameter int TICKS_PER_SECOND = 5,
    parameter int LED_COUNT        = 8
) (
    input  toc_pkg::state_t  cur,
    input  toc_pkg::cfg_t    cfg,
    input  toc_pkg::event_t  evt,
    output toc_pkg::state_t  nxt,
    output toc_pkg::result_t res
);

    // LED interval and remainder for each cook time 1..256, indexed by time - 1
    logic [15:0] interval_tab [256];
    logic [2:0]  rem_tab [256];

    for (genvar i = 0; i < 256; i++) begin : g_tab
        localparam int TOTAL = (i + 1) * TICKS_PER_SECOND;
        assign interval_tab[i] = 16'(TOTAL / LED_COUNT);
        assign rem_tab[i]      = 3'(TOTAL % LED_COUNT);
    end

    logic [7:0]               knob;
    logic                     b3down, b3up, b4down, b4up;
    logic [15:0]              frc_new;
    logic [15:0]              elapsed;
    logic [toc_pkg::SUB_W-1:0] sub_new;
    logic                     sec_edge;
    logic                     long_press;
    logic                     edit_temp;
    logic [7:0]               tab_idx;
    logic [15:0]              tc_inc;
    logic                     fire;
    logic [15:0]              tc_tick;
    logic [2:0]               rem_tick;
    logic [7:0]               led_tick;
    logic [8:0]               left_dec;
    logic [1:0]               mode_inc;

    assign knob   = evt.adc_sample[9:2];
    assign b3down = evt.button_events[0];
    assign b3up   = evt.button_events[1];
    assign b4down = evt.button_events[2];
    assign b4up   = evt.button_events[3];

    assign frc_new = cur.frc + 16'(evt.tick);
    assign elapsed = frc_new - cur.stamp;

    // sub tracks elapsed mod ticks-per-second; the 16-bit elapsed wrap restarts it
    always_comb
    begin
        sub_new = cur.sub;
        if (evt.tick)
        begin
            if (elapsed == 16'd0 || cur.sub == toc_pkg::SUB_W'(TICKS_PER_SECOND - 1))
                sub_new = '0;
            else
                sub_new = cur.sub + toc_pkg::SUB_W'(1);
        end
    end

    assign sec_edge   = (sub_new == '0);
    assign long_press = (elapsed >= 16'(TICKS_PER_SECOND));
    assign edit_temp  = (cur.mode == toc_pkg::MODE_BAKE) && cur.edit;
    assign tab_idx    = (evt.adc_fresh && !edit_temp) ? knob : 8'(cur.cook - 9'd1);

    // LED bar timer advanced by one tick
    assign tc_inc   = cur.tcount + 16'd1;
    assign fire     = (cur.rem != 3'd0) ? (tc_inc == cur.interval + 16'd1)
                                        : (tc_inc == cur.interval);
    assign tc_tick  = fire ? 16'd0 : tc_inc;
    assign rem_tick = (fire && cur.rem != 3'd0) ? cur.rem - 3'd1 : cur.rem;
    assign led_tick = fire ? {cur.led[6:0], 1'b0} : cur.led;

    assign left_dec = cur.left - 9'd1;
    assign mode_inc = (cur.mode >= toc_pkg::MODE_BROIL) ? toc_pkg::MODE_BAKE
                                                        : cur.mode + 2'd1;

    always_comb
    begin
        nxt     = cur;
        nxt.frc = frc_new;
        nxt.sub = sub_new;
        unique case (cur.phase)
            toc_pkg::PH_SELECT:
            begin
                if (b3up)
                begin
                    if (long_press)
                    begin
                        if (cur.mode == toc_pkg::MODE_BAKE)
                            nxt.edit = ~cur.edit;
                    end
                    else
                    begin
                        nxt.mode = mode_inc;
                        if (mode_inc == toc_pkg::MODE_BROIL)
                        begin
                            nxt.saved = cur.temp;
                            nxt.temp  = {1'b0, cfg.broil};
                        end
                        else if (mode_inc == toc_pkg::MODE_BAKE)
                            nxt.temp = cur.saved;
                    end
                    nxt.phase = toc_pkg::PH_SETUP;
                end
            end

            toc_pkg::PH_COOK:
            begin
                if (evt.tick)
                begin
                    nxt.tcount = tc_tick;
                    nxt.rem    = rem_tick;
                    nxt.led    = led_tick;
                    if (cur.left == 9'd0)
                    begin
                        nxt.left  = cur.cook;
                        nxt.phase = toc_pkg::PH_FLASH;
                        nxt.led   = 8'd0;
                    end
                    else if (sec_edge)
                        nxt.left = left_dec;
                end
                // a time-out in this word drops the button flags
                if (b4down && !(evt.tick && cur.left == 9'd0))
                begin
                    nxt.phase = toc_pkg::PH_RESET;
                    nxt.stamp = frc_new;
                    nxt.sub   = '0;
                end
            end

            toc_pkg::PH_RESET:
            begin
                if (evt.tick)
                begin
                    nxt.tcount = tc_tick;
                    nxt.rem    = rem_tick;
                    nxt.led    = led_tick;
                    if (long_press)
                    begin
                        nxt.left  = cur.cook;
                        nxt.phase = toc_pkg::PH_SETUP;
                        nxt.led   = 8'd0;
                    end
                    else if (sec_edge && cur.left != 9'd0)
                        nxt.left = left_dec;
                end
                if (b4up && !long_press)
                    nxt.phase = toc_pkg::PH_COOK;
            end

            toc_pkg::PH_FLASH:
            begin
                if (evt.tick)
                    nxt.flash = ~cur.flash;
                if (b4up)
                begin
                    nxt.flash = 1'b1;
                    nxt.phase = toc_pkg::PH_SETUP;
                end
            end

            default:
            begin
                if (evt.adc_fresh)
                begin
                    if (edit_temp)
                        nxt.temp = 11'(knob) + 11'(cfg.offset);
                    else
                    begin
                        nxt.cook = 9'(knob) + 9'd1;
                        nxt.left = 9'(knob) + 9'd1;
                    end
                end
                if (b3down)
                begin
                    nxt.stamp = frc_new;
                    nxt.sub   = '0;
                    nxt.phase = toc_pkg::PH_SELECT;
                end
                if (b4down)
                begin
                    nxt.phase    = toc_pkg::PH_COOK;
                    nxt.stamp    = frc_new;
                    nxt.sub      = '0;
                    nxt.led      = 8'hFF;
                    nxt.interval = interval_tab[tab_idx];
                    nxt.rem      = rem_tab[tab_idx];
                    nxt.tcount   = 16'd0;
                end
            end
        endcase
    end

    always_comb
    begin
        res.phase               = nxt.phase;
        res.cook_mode           = nxt.mode;
        res.cook_seconds        = nxt.cook;
        res.seconds_left        = nxt.left;
        res.oven_temperature    = nxt.temp;
        res.editing_temperature = nxt.edit;
        res.led_bar             = nxt.led;
        res.display_inverted    = (nxt.phase == toc_pkg::PH_FLASH) && !nxt.flash;
    end

endmodule

FILE: hdl/toaster_oven_controller.sv
// Top level of the toaster oven controller: input register, state, result register.
//
//  channel  direction  word
//  evt      in         tick, adc_fresh, adc_sample, button_events
//  res      out        phase, mode, cook/left seconds, temperature, edit, LEDs, inverted
//  cfg      in         index (0 broil temperature, 1 temperature offset), data
//
// One event word per clock unless the result side stalls; a taken word goes from the
// input register through next-state logic into the state and result registers.
// A stalled result holds the input register; evt.ready drops only when both are full.
// Reset clears state, config and valid flags; no clearing pass. Register writes are always taken.
`include "toaster_oven_controller_defines.svh"

module toaster_oven_controller #(
    parameter int TICKS_PER_SECOND = 5,
    parameter int LED_COUNT        = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    toc_event_if.sink    evt,
    toc_result_if.source res,
    toc_cfg_if.sink      cfg
);

    toc_pkg::state_t  state_reg;
    toc_pkg::state_t  state_next;
    toc_pkg::cfg_t    cfg_reg;
    toc_pkg::event_t  evt_reg;
    logic             evt_valid_reg;
    toc_pkg::result_t res_reg;
    toc_pkg::result_t res_next;
    logic             res_valid_reg;
    logic             res_free;
    logic             evt_adv;
    logic             leds_allowed;

    assign res_free  = !res_valid_reg || res.ready;
    assign evt_adv   = evt_valid_reg && res_free;
    assign evt.ready = !evt_valid_reg || res_free;
    assign cfg.ready = 1'b1;

    toc_step #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .LED_COUNT        (LED_COUNT)
    ) u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .evt (evt_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                evt_valid_reg <= evt.valid;
            if (res_free)
                res_valid_reg <= evt_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= toc_pkg::STATE_RESET;
        else if (evt_adv)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= toc_pkg::CFG_RESET;
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                toc_pkg::CFG_BROIL:  cfg_reg.broil  <= cfg.data;
                toc_pkg::CFG_OFFSET: cfg_reg.offset <= cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            evt_reg.tick          <= evt.tick;
            evt_reg.adc_fresh     <= evt.adc_fresh;
            evt_reg.adc_sample    <= evt.adc_sample;
            evt_reg.button_events <= evt.button_events;
        end
        if (evt_adv)
            res_reg <= res_next;
    end

    assign res.valid               = res_valid_reg;
    assign res.phase               = res_reg.phase;
    assign res.cook_mode           = res_reg.cook_mode;
    assign res.cook_seconds        = res_reg.cook_seconds;
    assign res.seconds_left        = res_reg.seconds_left;
    assign res.oven_temperature    = res_reg.oven_temperature;
    assign res.editing_temperature = res_reg.editing_temperature;
    assign res.led_bar             = res_reg.led_bar;
    assign res.display_inverted    = res_reg.display_inverted;

    assign leds_allowed = (state_reg.led == 8'd0) || (state_reg.phase == toc_pkg::PH_COOK)
                          || (state_reg.phase == toc_pkg::PH_RESET);

    // cook time stays in 1..256
    `TOC_ASSERT(a_cook_range, state_reg.cook != 9'd0 && state_reg.cook <= 9'd256)
    // LEDs are lit only while cooking or deciding on a reset
    `TOC_ASSERT(a_led_phase, leds_allowed)
    // done flash reloads the remaining time
    `TOC_ASSERT(a_flash_left, state_reg.phase != toc_pkg::PH_FLASH || state_reg.left == state_reg.cook)
    `TOC_ASSERT(a_rem_range, {1'b0, state_reg.rem} < 4'(LED_COUNT))
    // a word waiting behind a stalled result is neither lost nor changed
    `TOC_ASSERT_NEXT(a_evt_hold, evt_valid_reg && !res_free, evt_valid_reg && $stable(evt_reg))

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the toaster oven controller: directed and random event words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_PER_SECOND = 5;
    localparam int LED_COUNT        = 8;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_WORDS     = 470;
    localparam int TAIL_CYCLES      = 10;

    localparam logic [3:0] B3_DOWN = 4'b0001;
    localparam logic [3:0] B3_UP   = 4'b0010;
    localparam logic [3:0] B4_DOWN = 4'b0100;
    localparam logic [3:0] B4_UP   = 4'b1000;

    logic clk = 1'b0;
    logic rst_n;

    toc_event_if  evt_ch ();
    toc_result_if res_ch ();
    toc_cfg_if    cfg_ch ();

    toaster_oven_controller #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .LED_COUNT       (LED_COUNT)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .evt  (evt_ch),
        .res  (res_ch),
        .cfg  (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // oven model state
    logic [2:0]  oven_phase;
    logic [1:0]  oven_mode;
    logic [8:0]  set_seconds;
    logic [8:0]  left_seconds;
    logic [10:0] set_temp;
    logic [10:0] bake_temp_saved;
    logic        temp_edit;
    logic [15:0] press_tick;
    logic [15:0] tick_clock;
    logic [15:0] led_ticks;
    logic [15:0] led_period;
    logic [2:0]  led_extra;
    logic [7:0]  led_pattern;
    logic        flash_phase;
    logic [9:0]  broil_cfg;
    logic [9:0]  offset_cfg;

    toc_pkg::result_t expected_status[$];

    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int error_count    = 0;
    int events_sent    = 0;
    int statuses_seen  = 0;
    int cfg_writes     = 0;
    int quiet_cycles   = 0;
    int phase_seen[5]  = '{default: 0};

    function automatic void reset_oven_model();
        oven_phase      = toc_pkg::PH_SETUP;
        oven_mode       = toc_pkg::MODE_BAKE;
        set_seconds     = 9'd1;
        left_seconds    = 9'd1;
        set_temp        = 11'd350;
        bake_temp_saved = 11'd0;
        temp_edit       = 1'b0;
        press_tick      = 16'd0;
        tick_clock      = 16'd0;
        led_ticks       = 16'd0;
        led_period      = 16'd0;
        led_extra       = 3'd0;
        led_pattern     = 8'd0;
        flash_phase     = 1'b0;
        broil_cfg       = 10'd500;
        offset_cfg      = 10'd300;
    endfunction

    // LED bar shifts out one LED per interval; the first few intervals run one tick longer
    function automatic void advance_leds();
        logic fire;
        led_ticks = led_ticks + 16'd1;
        if (led_extra != 3'd0)
            fire = ({1'b0, led_ticks} == {1'b0, led_period} + 17'd1);
        else
            fire = (led_ticks == led_period);
        if (fire)
        begin
            led_ticks = 16'd0;
            if (led_extra != 3'd0)
                led_extra = led_extra - 3'd1;
            led_pattern = led_pattern << 1;
        end
    endfunction

    function automatic toc_pkg::result_t next_status(toc_pkg::event_t e);
        toc_pkg::result_t r;
        logic [7:0]       knob;
        logic [15:0]      since;
        int               total;
        knob = e.adc_sample[9:2];
        if (e.tick)
            tick_clock = tick_clock + 16'd1;
        since = tick_clock - press_tick;
        case (oven_phase)
            toc_pkg::PH_SELECT:
            begin
                if (e.button_events & B3_UP)
                begin
                    if (since >= TICKS_PER_SECOND)
                    begin
                        if (oven_mode == toc_pkg::MODE_BAKE)
                            temp_edit = ~temp_edit;
                    end
                    else
                    begin
                        oven_mode = (oven_mode >= toc_pkg::MODE_BROIL) ? toc_pkg::MODE_BAKE
                                                                       : oven_mode + 2'd1;
                        if (oven_mode == toc_pkg::MODE_BROIL)
                        begin
                            bake_temp_saved = set_temp;
                            set_temp        = {1'b0, broil_cfg};
                        end
                        else if (oven_mode == toc_pkg::MODE_BAKE)
                            set_temp = bake_temp_saved;
                    end
                    oven_phase = toc_pkg::PH_SETUP;
                end
            end
            toc_pkg::PH_COOK:
            begin
                if (e.tick)
                begin
                    advance_leds();
                    if (left_seconds == 9'd0)
                    begin
                        // timed out: buttons of this word are dropped
                        left_seconds = set_seconds;
                        oven_phase   = toc_pkg::PH_FLASH;
                        led_pattern  = 8'd0;
                    end
                    else if (since % TICKS_PER_SECOND == 0)
                        left_seconds = left_seconds - 9'd1;
                end
                if (oven_phase == toc_pkg::PH_COOK && (e.button_events & B4_DOWN))
                begin
                    oven_phase = toc_pkg::PH_RESET;
                    press_tick = tick_clock;
                end
            end
            toc_pkg::PH_RESET:
            begin
                if (e.tick)
                begin
                    advance_leds();
                    if (since % TICKS_PER_SECOND == 0 && left_seconds != 9'd0)
                        left_seconds = left_seconds - 9'd1;
                    if (since >= TICKS_PER_SECOND)
                    begin
                        left_seconds = set_seconds;
                        oven_phase   = toc_pkg::PH_SETUP;
                        led_pattern  = 8'd0;
                    end
                end
                if (oven_phase == toc_pkg::PH_RESET && (e.button_events & B4_UP)
                        && since < TICKS_PER_SECOND)
                    oven_phase = toc_pkg::PH_COOK;
            end
            toc_pkg::PH_FLASH:
            begin
                if (e.tick)
                    flash_phase = ~flash_phase;
                if (e.button_events & B4_UP)
                begin
                    flash_phase = 1'b1;
                    oven_phase  = toc_pkg::PH_SETUP;
                end
            end
            default:
            begin
                if (e.adc_fresh)
                begin
                    if (oven_mode == toc_pkg::MODE_BAKE && temp_edit)
                        set_temp = {3'b000, knob} + {1'b0, offset_cfg};
                    else
                    begin
                        set_seconds  = {1'b0, knob} + 9'd1;
                        left_seconds = set_seconds;
                    end
                end
                if (e.button_events & B3_DOWN)
                begin
                    press_tick = tick_clock;
                    oven_phase = toc_pkg::PH_SELECT;
                end
                // b4 down is handled last, so it wins over b3 down
                if (e.button_events & B4_DOWN)
                begin
                    total       = set_seconds * TICKS_PER_SECOND;
                    oven_phase  = toc_pkg::PH_COOK;
                    press_tick  = tick_clock;
                    led_pattern = 8'hFF;
                    led_period  = 16'(total / LED_COUNT);
                    led_extra   = 3'(total % LED_COUNT);
                    led_ticks   = 16'd0;
                end
            end
        endcase
        r.phase               = oven_phase;
        r.cook_mode           = oven_mode;
        r.cook_seconds        = set_seconds;
        r.seconds_left        = left_seconds;
        r.oven_temperature    = set_temp;
        r.editing_temperature = temp_edit;
        r.led_bar             = led_pattern;
        r.display_inverted    = (oven_phase == toc_pkg::PH_FLASH && !flash_phase);
        return r;
    endfunction

    function automatic toc_pkg::event_t make_event(logic t, logic a, logic [9:0] s,
                                                   logic [3:0] b);
        toc_pkg::event_t e;
        e.tick          = t;
        e.adc_fresh     = a;
        e.adc_sample    = s;
        e.button_events = b;
        return e;
    endfunction

    // mostly well-formed traffic for the current phase, with some fully random words
    function automatic toc_pkg::event_t pick_event();
        toc_pkg::event_t e;
        int              roll;
        e = '0;
        if ($urandom_range(99) < 8)
            return make_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                              10'($urandom_range(1023)), 4'($urandom_range(15)));
        case (oven_phase)
            toc_pkg::PH_SELECT:
            begin
                e.tick = ($urandom_range(99) < 70);
                if ($urandom_range(99) < 20)
                    e.button_events = B3_UP;
            end
            toc_pkg::PH_COOK:
            begin
                e.tick = ($urandom_range(99) < 85);
                if ($urandom_range(99) < 2)
                    e.button_events = B4_DOWN;
            end
            toc_pkg::PH_RESET:
            begin
                e.tick = ($urandom_range(99) < 60);
                if ($urandom_range(99) < 15)
                    e.button_events = B4_UP;
            end
            toc_pkg::PH_FLASH:
            begin
                e.tick = 1'($urandom_range(1));
                if ($urandom_range(99) < 25)
                    e.button_events = B4_UP;
            end
            default:
            begin
                e.tick = 1'($urandom_range(1));
                roll   = $urandom_range(99);
                if (roll < 35)
                begin
                    e.adc_fresh = 1'b1;
                    // short cook times mostly, so sessions run to the end
                    if ($urandom_range(3) != 0)
                        e.adc_sample = 10'($urandom_range(15));
                    else
                        e.adc_sample = 10'($urandom_range(1023));
                end
                else if (roll < 65)
                    e.button_events = B3_DOWN;
                else if (roll < 85)
                    e.button_events = B4_DOWN;
            end
        endcase
        return e;
    endfunction

    task automatic send_event(input toc_pkg::event_t e);
        evt_ch.valid         <= 1'b1;
        evt_ch.tick          <= e.tick;
        evt_ch.adc_fresh     <= e.adc_fresh;
        evt_ch.adc_sample    <= e.adc_sample;
        evt_ch.button_events <= e.button_events;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        expected_status.push_back(next_status(e));
        events_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_all_status();
        evt_ch.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [9:0] value);
        wait_all_status();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == toc_pkg::CFG_BROIL)
            broil_cfg = value;
        else
            offset_cfg = value;
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // reset status, knob extremes, both buttons in one word, timeout with a button pending
    task automatic test_reset_and_timeout();
        send_event(make_event(1'b0, 1'b0, 10'd0, 4'd0));
        send_event(make_event(1'b0, 1'b1, 10'd1023, 4'd0));
        send_event(make_event(1'b0, 1'b1, 10'd3, 4'd0));
        send_event(make_event(1'b0, 1'b0, 10'd0, B3_DOWN | B4_DOWN));
        repeat (5)
            send_event(make_event(1'b1, 1'b0, 10'd0, 4'd0));
        send_event(make_event(1'b1, 1'b0, 10'd0, B4_DOWN));
        send_event(make_event(1'b1, 1'b0, 10'd0, 4'd0));
        send_event(make_event(1'b0, 1'b0, 10'd0, B4_UP));
    endtask

    // long press toggles temperature edit, short presses walk bake, toast, broil, bake
    task automatic test_mode_cycle();
        write_register(toc_pkg::CFG_BROIL, 10'd1023);
        write_register(toc_pkg::CFG_OFFSET, 10'd1023);
        send_event(make_event(1'b0, 1'b0, 10'd0, B3_DOWN));
        repeat (TICKS_PER_SECOND)
            send_event(make_event(1'b1, 1'b0, 10'd0, 4'd0));
        send_event(make_event(1'b0, 1'b0, 10'd0, B3_UP));
        send_event(make_event(1'b0, 1'b1, 10'd1023, 4'd0));
        repeat (3)
        begin
            send_event(make_event(1'b0, 1'b0, 10'd0, B3_DOWN));
            send_event(make_event(1'b1, 1'b0, 10'd0, B3_UP));
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
            send_event(pick_event());
    endtask

    function automatic void compare_field(string name, logic [10:0] want, logic [10:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        toc_pkg::result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            statuses_seen++;
            if (res_ch.phase <= toc_pkg::PH_FLASH)
                phase_seen[res_ch.phase]++;
            if (expected_status.size() == 0)
            begin
                $error("status word arrived with none predicted");
                error_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                compare_field("phase", 11'(want.phase), 11'(res_ch.phase));
                compare_field("cook_mode", 11'(want.cook_mode), 11'(res_ch.cook_mode));
                compare_field("cook_seconds", 11'(want.cook_seconds),
                              11'(res_ch.cook_seconds));
                compare_field("seconds_left", 11'(want.seconds_left),
                              11'(res_ch.seconds_left));
                compare_field("oven_temperature", want.oven_temperature,
                              res_ch.oven_temperature);
                compare_field("editing_temperature", 11'(want.editing_temperature),
                              11'(res_ch.editing_temperature));
                compare_field("led_bar", 11'(want.led_bar), 11'(res_ch.led_bar));
                compare_field("display_inverted", 11'(want.display_inverted),
                              11'(res_ch.display_inverted));
            end
        end
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n                <= 1'b0;
        evt_ch.valid         <= 1'b0;
        evt_ch.tick          <= 1'b0;
        evt_ch.adc_fresh     <= 1'b0;
        evt_ch.adc_sample    <= 10'd0;
        evt_ch.button_events <= 4'd0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= toc_pkg::CFG_BROIL;
        cfg_ch.data          <= 10'd0;
        reset_oven_model();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_timeout();
        test_mode_cycle();
        write_register(toc_pkg::CFG_BROIL, 10'd0);
        write_register(toc_pkg::CFG_OFFSET, 10'd0);
        test_random_traffic(0, 0, RANDOM_WORDS);
        write_register(toc_pkg::CFG_BROIL, 10'($urandom_range(1023)));
        write_register(toc_pkg::CFG_OFFSET, 10'($urandom_range(1023)));
        test_random_traffic(80, 0, RANDOM_WORDS);
        write_register(toc_pkg::CFG_BROIL, 10'd1023);
        write_register(toc_pkg::CFG_OFFSET, 10'd0);
        test_random_traffic(0, 80, RANDOM_WORDS);
        write_register(toc_pkg::CFG_BROIL, 10'($urandom_range(1023)));
        write_register(toc_pkg::CFG_OFFSET, 10'($urandom_range(1023)));
        test_random_traffic(36, 36, RANDOM_WORDS);

        wait_all_status();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Sent %0d event words, checked %0d status words, %0d register writes.",
                 events_sent, statuses_seen, cfg_writes);
        $display("By phase: setup %0d, selector %0d, cooking %0d, reset %0d, flash %0d.",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4]);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
